/* src/utf8_fixed_field_validator_top_macros.svh */
// ---------------------------------------------------------------------------
// utf8 fixed field validator assertion macros
// shared helpers for concurrent checks clocked on clk with async low reset
// ---------------------------------------------------------------------------
`ifndef UTF8_FIXED_FIELD_VALIDATOR_TOP_MACROS_SVH
`define UTF8_FIXED_FIELD_VALIDATOR_TOP_MACROS_SVH

// same-cycle implication
`define U8FFV_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8ffv check failed");

// next-cycle implication
`define U8FFV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8ffv check failed");

`endif

/* src/u8ffv_pkg.sv */
// ---------------------------------------------------------------------------
// u8ffv_pkg
// types, codes and byte class limits for the utf8 fixed field validator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8ffv_pkg;

    localparam int DEFAULT_LENGTH_BITS = 16;
    localparam int BUDGET_W            = 16;
    localparam int BYTE_W              = 8;
    localparam int ERR_W               = 2;
    localparam int IN_DATA_W           = 24;
    localparam int OUT_DATA_W          = 16;

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_MALFORMED = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OVERRUN   = 2'd2;

    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] LEAD2_MIN  = 8'hC2;
    localparam logic [7:0] LEAD2_MAX  = 8'hDF;
    localparam logic [7:0] LEAD3_MIN  = 8'hE0;
    localparam logic [7:0] LEAD3_MAX  = 8'hEF;
    localparam logic [7:0] LEAD4_MIN  = 8'hF0;
    localparam logic [7:0] LEAD4_MAX  = 8'hF4;
    localparam logic [7:0] LEAD_E0    = 8'hE0;
    localparam logic [7:0] LEAD_ED    = 8'hED;
    localparam logic [7:0] LEAD_F0    = 8'hF0;
    localparam logic [7:0] LEAD_F4    = 8'hF4;
    localparam logic [7:0] E0_CONT_MIN = 8'hA0;
    localparam logic [7:0] ED_CONT_MAX = 8'h9F;
    localparam logic [7:0] F0_CONT_MIN = 8'h90;
    localparam logic [7:0] F4_CONT_MAX = 8'h8F;
    localparam logic [7:0] CONT_MIN   = 8'h80;
    localparam logic [7:0] CONT_MAX   = 8'hBF;

    typedef struct packed {
        logic              accepted;
        logic              keep;
        logic [BYTE_W-1:0] out_byte;
        logic              done_res;
        logic [ERR_W-1:0]  error;
    } result_t;

    // sequence length of a lead byte, zero when the byte cannot start one
    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd0;
        if (b <= ASCII_MAX) begin
            n = 3'd1;
        end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
            n = 3'd2;
        end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
            n = 3'd3;
        end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
            n = 3'd4;
        end
        return n;
    endfunction

    // continuation byte check, with the tighter first-byte ranges
    function automatic logic cont_ok(input logic [7:0] lead, input logic first,
                                     input logic [7:0] b);
        logic ok;
        ok = (b >= CONT_MIN) && (b <= CONT_MAX);
        if (first) begin
            if (lead == LEAD_E0 && b < E0_CONT_MIN) ok = 1'b0;
            if (lead == LEAD_ED && b > ED_CONT_MAX) ok = 1'b0;
            if (lead == LEAD_F0 && b < F0_CONT_MIN) ok = 1'b0;
            if (lead == LEAD_F4 && b > F4_CONT_MAX) ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

/* src/utf8_fixed_field_validator_top.sv */
// ---------------------------------------------------------------------------
// utf8_fixed_field_validator_top
// strict utf-8 checker for a text field sized in utf-16 units
// ---------------------------------------------------------------------------
// One result word per input word, appearing in the cycle after the input is taken. A new
// word is taken every cycle while the result register is empty or being
// drained, so the sustained rate is one word per clock; the single result
// register is the only stage between the two sides. A begin word (tuser 0)
// loads the unit budget from tdata[15:0]; byte words (tuser 1) carry the byte
// in tdata[23:16]. Zero bytes are pad, dropped and counted as one unit; a
// four-byte character costs two units. tlast marks the result that uses up the budget
// exactly, or a zero-budget begin; after it or an error, bytes get accepted 0 until a begin.
`timescale 1ns / 1ps

`include "utf8_fixed_field_validator_top_macros.svh"

module utf8_fixed_field_validator_top
    import u8ffv_pkg::*;
#(
    parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // unit_budget[15:0], data_byte[23:16]
    input  logic                  s_axis_tuser,  // cmd
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // accepted[0], out_byte[8:1], error[10:9]
    output logic                  m_axis_tuser,  // keep
    output logic                  m_axis_tlast   // done_res
);

    logic                   active_reg, active_next;
    logic [LENGTH_BITS-1:0] units_reg, units_next;
    logic [LENGTH_BITS-1:0] budget_reg, budget_next;
    logic [BYTE_W-1:0]      lead_reg, lead_next;
    logic [1:0]             cont_left_reg, cont_left_next;
    logic                   first_cont_reg, first_cont_next;
    logic [1:0]             pending_reg, pending_next;
    logic                   out_valid_reg;
    result_t                res_reg, res_next;

    logic                   in_fire;
    logic [BUDGET_W-1:0]    in_budget;
    logic [BYTE_W-1:0]      in_byte;
    logic [2:0]             nbytes;
    logic [1:0]             nunits;
    logic [1:0]             add_n;
    logic                   do_add;
    logic [LENGTH_BITS-1:0] units_sum;
    logic [LENGTH_BITS:0]   units_need;

    assign in_budget     = s_axis_tdata[BUDGET_W-1:0];
    assign in_byte       = s_axis_tdata[BUDGET_W +: BYTE_W];
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign nbytes     = seq_len(in_byte);
    assign nunits     = (nbytes == 3'd4) ? 2'd2 : 2'd1;
    assign units_need = {1'b0, units_reg} + (LENGTH_BITS + 1)'(nunits);
    assign units_sum  = units_reg + LENGTH_BITS'(add_n);

    always_comb
    begin
        active_next     = active_reg;
        units_next      = units_reg;
        budget_next     = budget_reg;
        lead_next       = lead_reg;
        cont_left_next  = cont_left_reg;
        first_cont_next = first_cont_reg;
        pending_next    = pending_reg;
        res_next        = '0;
        do_add          = 1'b0;
        add_n           = 2'd1;

        if (s_axis_tuser == CMD_BEGIN) begin
            budget_next     = LENGTH_BITS'(in_budget);
            units_next      = '0;
            lead_next       = '0;
            cont_left_next  = '0;
            first_cont_next = 1'b0;
            pending_next    = '0;
            if (LENGTH_BITS'(in_budget) == '0) begin
                active_next       = 1'b0;
                res_next.done_res = 1'b1;
            end else begin
                active_next = 1'b1;
            end
        end else if (active_reg) begin
            res_next.accepted = 1'b1;
            if (cont_left_reg == 2'd0) begin
                if (in_byte == '0) begin
                    do_add = 1'b1;
                end else if (nbytes == 3'd0) begin
                    res_next.error = ERR_MALFORMED;
                end else if (units_need > {1'b0, budget_reg}) begin
                    res_next.error = ERR_OVERRUN;
                end else begin
                    res_next.keep     = 1'b1;
                    res_next.out_byte = in_byte;
                    if (nbytes == 3'd1) begin
                        do_add = 1'b1;
                    end else begin
                        lead_next       = in_byte;
                        cont_left_next  = 2'(nbytes - 3'd1);
                        first_cont_next = 1'b1;
                        pending_next    = nunits;
                    end
                end
            end else begin
                if (!cont_ok(lead_reg, first_cont_reg, in_byte)) begin
                    res_next.error = ERR_MALFORMED;
                end else begin
                    res_next.keep     = 1'b1;
                    res_next.out_byte = in_byte;
                    first_cont_next   = 1'b0;
                    cont_left_next    = cont_left_reg - 2'd1;
                    if (cont_left_reg == 2'd1) begin
                        pending_next = '0;
                        do_add       = 1'b1;
                        add_n        = pending_reg;
                    end
                end
            end

            if (res_next.error != ERR_NONE) begin
                active_next     = 1'b0;
                cont_left_next  = '0;
                first_cont_next = 1'b0;
                pending_next    = '0;
            end

            if (do_add) begin
                units_next = units_sum;
                if (units_sum == budget_reg) begin
                    res_next.done_res = 1'b1;
                    active_next       = 1'b0;
                    cont_left_next    = '0;
                    first_cont_next   = 1'b0;
                    pending_next      = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_reg     <= 1'b0;
            units_reg      <= '0;
            budget_reg     <= '0;
            lead_reg       <= '0;
            cont_left_reg  <= '0;
            first_cont_reg <= 1'b0;
            pending_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (in_fire) begin
                active_reg     <= active_next;
                units_reg      <= units_next;
                budget_reg     <= budget_next;
                lead_reg       <= lead_next;
                cont_left_reg  <= cont_left_next;
                first_cont_reg <= first_cont_next;
                pending_reg    <= pending_next;
                out_valid_reg  <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = res_reg.keep;
    assign m_axis_tlast  = res_reg.done_res;
    assign m_axis_tdata  = {{(OUT_DATA_W - ERR_W - BYTE_W - 1){1'b0}},
                            res_reg.error, res_reg.out_byte, res_reg.accepted};

    // a kept byte or an error always belongs to a consumed word
    `U8FFV_ASSERT_SAME(a_keep_accepted, m_axis_tvalid && m_axis_tuser, m_axis_tdata[0])
    `U8FFV_ASSERT_SAME(a_err_no_keep, m_axis_tvalid && (m_axis_tdata[10:9] != ERR_NONE),
                       m_axis_tdata[0] && !m_axis_tuser)
    // an open sequence needs an open field
    `U8FFV_ASSERT_SAME(a_cont_active, cont_left_reg != 2'd0, active_reg)
    // errors and completion close the field
    `U8FFV_ASSERT_NEXT(a_err_closes, in_fire && (res_next.error != ERR_NONE), !active_reg)
    `U8FFV_ASSERT_NEXT(a_done_closes, in_fire && res_next.done_res, !active_reg)

endmodule
